>>> rtl/dnmd_pkg.sv
// ---------------------------------------------------------------------------
// dnmd_pkg: shared types and constants
// command word between controller and datapath
// ---------------------------------------------------------------------------
`default_nettype none
package dnmd_pkg;
  localparam int MaxPoints = 65536;
  localparam int CountW = $clog2(MaxPoints + 1);
  localparam int OutCountW = 17;
  localparam logic [1:0] CfgCx = 2'd0;
  localparam logic [1:0] CfgCy = 2'd1;
  localparam logic [1:0] CfgCz = 2'd2;
  localparam logic [1:0] CfgRad = 2'd3;

  typedef struct packed {
    logic accum;      // run the disc test and accumulate
    logic fin_start;  // latch sums and begin the divide/sqrt pass
    logic div_step;   // one bit of the mean divides
    logic sq_load;    // load the root radicand from the finished means
    logic sq_step;    // one step of the square root
    logic nd_step;    // one bit of the normalise divides
    logic clear;      // clear sums and count
  } cmd_t;
endpackage
`default_nettype wire

>>> rtl/disc_neighborhood_mean_direction_top.sv
// ---------------------------------------------------------------------------
// disc_neighborhood_mean_direction_top: disc mean tangent direction
// tests points against a disc and gives the normalised mean tangent
// ---------------------------------------------------------------------------
// Each ordinary point word gets a disc test and, for a point inside the
// disc, a saturating add of the flipped tangent into three sums. The word
// marked last starts a finishing pass (the bit-serial mean divides, the
// square root including the load of its radicand, the normalise divides,
// then the load of the result register), during which input is stalled;
// the set's result word is then held until taken, input stays stalled
// while it waits, and the sums are cleared as the result word is loaded.
`default_nettype none
module disc_neighborhood_mean_direction_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic signed [15:0] tan_x,
  input  wire logic signed [15:0] tan_y,
  input  wire logic signed [15:0] tan_z,
  input  wire logic last,
  output logic out_valid,
  input  wire logic out_stall,
  output logic signed [15:0] mean_x,
  output logic signed [15:0] mean_y,
  output logic signed [15:0] mean_z,
  output logic valid_res,
  output logic [16:0] disk_count,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  dnmd_pkg::cmd_t cmd;
  logic in_fire, out_load, out_take;
  logic signed [15:0] rx, ry, rz;
  logic rok;
  logic [16:0] rc;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  dnmd_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(last), .out_busy(out_valid), .out_take,
    .in_stall, .out_load, .cmd
  );

  dnmd_dp u_dp (
    .clk, .rst, .cmd, .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .point_x, .point_y, .point_z, .tan_x, .tan_y, .tan_z,
    .res_x(rx), .res_y(ry), .res_z(rz), .res_ok(rok), .res_cnt(rc)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      mean_x <= rx; mean_y <= ry; mean_z <= rz;
      valid_res <= rok; disk_count <= rc;
    end
  end
endmodule
`default_nettype wire

>>> rtl/dnmd_ctrl.sv
// ---------------------------------------------------------------------------
// dnmd_ctrl: sequencer
// steps the finishing pass for the last word of a set
// ---------------------------------------------------------------------------
`default_nettype none
module dnmd_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic in_last,
  input  wire logic out_busy,
  input  wire logic out_take,
  output logic in_stall,
  output logic out_load,
  output dnmd_pkg::cmd_t cmd
);
  typedef enum logic [2:0] {S_RUN, S_DIV, S_SQ, S_ND, S_OUT} state_t;
  state_t state;
  logic [5:0] cnt;

  assign in_stall = (state != S_RUN) || out_busy;
  assign out_load = (state == S_OUT) && (!out_busy || out_take);

  always_comb begin
    cmd = '0;
    cmd.accum = in_fire;
    cmd.fin_start = in_fire && in_last;
    cmd.div_step = state == S_DIV;
    cmd.sq_load = (state == S_SQ) && (cnt == 6'd0);
    cmd.sq_step = (state == S_SQ) && (cnt != 6'd0);
    cmd.nd_step = state == S_ND;
    cmd.clear = out_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      cnt <= '0;
    end else begin
      unique case (state)
        S_RUN: if (in_fire && in_last) begin
          state <= S_DIV;
          cnt <= 6'd0;
        end
        S_DIV: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= S_SQ;
            cnt <= 6'd0;
          end
        end
        S_SQ: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd24) begin
            state <= S_ND;
            cnt <= 6'd0;
          end
        end
        S_ND: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd39) state <= S_OUT;
        end
        S_OUT: if (out_load) state <= S_RUN;
        default: state <= S_RUN;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/dnmd_dp.sv
// ---------------------------------------------------------------------------
// dnmd_dp: datapath
// disc test, tangent sums, bit-serial mean, square root and normalise
// ---------------------------------------------------------------------------
`default_nettype none
module dnmd_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dnmd_pkg::cmd_t cmd,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [31:0] cfg_data,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic signed [15:0] tan_x,
  input  wire logic signed [15:0] tan_y,
  input  wire logic signed [15:0] tan_z,
  output logic signed [15:0] res_x,
  output logic signed [15:0] res_y,
  output logic signed [15:0] res_z,
  output logic res_ok,
  output logic [16:0] res_cnt
);
  localparam int CW = dnmd_pkg::CountW;
  logic signed [31:0] cx, cy, cz;
  logic [30:0] rad;
  logic signed [31:0] sx, sy, sz;
  logic [CW-1:0] cnt;

  // disc test on the incoming word
  logic signed [32:0] dx, dy, dz;
  logic sat;
  logic [31:0] ax, ay, az;
  logic [65:0] d2;
  logic [61:0] r2;
  logic in_disc;
  logic signed [16:0] fx, fy, fz;
  logic [CW-1:0] cnt_a;
  logic signed [31:0] sx_a, sy_a, sz_a;

  function automatic logic signed [31:0] sadd(logic signed [31:0] a, logic signed [16:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) sadd = 32'sh7FFF_FFFF;
    else if (s < -33'sh0_8000_0000) sadd = 32'sh8000_0000;
    else sadd = s[31:0];
  endfunction

  always_comb begin
    dx = 33'(point_x) - 33'(cx);
    dy = 33'(point_y) - 33'(cy);
    dz = 33'(point_z) - 33'(cz);
    sat = (dx[32] != dx[31]) || (dy[32] != dy[31]) || (dz[32] != dz[31]);
    ax = dx[31] ? 32'(-dx) : dx[31:0];
    ay = dy[31] ? 32'(-dy) : dy[31:0];
    az = dz[31] ? 32'(-dz) : dz[31:0];
    d2 = 66'(ax * ax) + 66'(ay * ay) + 66'(az * az);
    r2 = rad * rad;
    in_disc = !sat && (ax < 32'd32768) && (d2 < 66'(r2)) && (cnt < CW'(dnmd_pkg::MaxPoints));
    if (tan_x < 0) begin
      fx = -17'(tan_x); fy = -17'(tan_y); fz = -17'(tan_z);
    end else begin
      fx = 17'(tan_x); fy = 17'(tan_y); fz = 17'(tan_z);
    end
    sx_a = sx; sy_a = sy; sz_a = sz; cnt_a = cnt;
    if (in_disc) begin
      sx_a = sadd(sx, fx); sy_a = sadd(sy, fy); sz_a = sadd(sz, fz);
      cnt_a = cnt + CW'(1);
    end
  end

  // finishing registers
  logic [31:0] mg [3];   // sum magnitudes, then quotient bits shift in
  logic [CW:0] rm [3];   // divide remainders
  logic ng [3];
  logic [CW-1:0] fcnt;
  logic [47:0] sq_n;
  logic [23:0] root;
  logic [25:0] sq_r;
  logic [40:0] nr [3];
  logic [39:0] nq [3];
  logic [39:0] nm [3];

  logic [16:0] m [3];
  assign m[0] = mg[0][16:0];
  assign m[1] = mg[1][16:0];
  assign m[2] = mg[2][16:0];
  logic [35:0] n2;
  assign n2 = 36'(m[0] * m[0]) + 36'(m[1] * m[1]) + 36'(m[2] * m[2]);
  logic [42:0] n2_100;
  assign n2_100 = 43'(n2) * 43'd100;

  logic [25:0] sq_trial;
  assign sq_trial = {sq_r[23:0], sq_n[47:46]} - {root, 2'b01};

  logic [15:0] o [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ng[i]) o[i] = (nq[i] > 40'd32768) ? 16'h8000 : 16'(-nq[i][15:0]);
      else o[i] = (nq[i] > 40'd32767) ? 16'h7FFF : nq[i][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0; cy <= '0; cz <= '0; rad <= 31'd65536;
      sx <= '0; sy <= '0; sz <= '0; cnt <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          dnmd_pkg::CfgCx: cx <= cfg_data;
          dnmd_pkg::CfgCy: cy <= cfg_data;
          dnmd_pkg::CfgCz: cz <= cfg_data;
          dnmd_pkg::CfgRad: rad <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (cmd.clear) begin
        sx <= '0; sy <= '0; sz <= '0; cnt <= '0;
      end else if (cmd.accum) begin
        sx <= sx_a; sy <= sy_a; sz <= sz_a; cnt <= cnt_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_start) begin
      mg[0] <= sx_a[31] ? 32'(-sx_a) : sx_a;
      mg[1] <= sy_a[31] ? 32'(-sy_a) : sy_a;
      mg[2] <= sz_a[31] ? 32'(-sz_a) : sz_a;
      ng[0] <= sx_a[31]; ng[1] <= sy_a[31]; ng[2] <= sz_a[31];
      fcnt <= cnt_a;
      for (int i = 0; i < 3; i++) rm[i] <= '0;
    end
    if (cmd.div_step) begin
      for (int i = 0; i < 3; i++) begin
        logic [CW:0] t;
        t = {rm[i][CW-1:0], mg[i][31]};
        if (t >= (CW+1)'(fcnt) && fcnt != '0) begin
          rm[i] <= t - (CW+1)'(fcnt);
          mg[i] <= {mg[i][30:0], 1'b1};
        end else begin
          rm[i] <= t;
          mg[i] <= {mg[i][30:0], 1'b0};
        end
      end
    end
    if (cmd.sq_load) begin
      // means are complete here
      sq_n <= {n2[31:0], 16'd0};
      root <= '0;
      sq_r <= '0;
    end
    if (cmd.sq_step) begin
      // restoring root, two bits of radicand per step
      if (!sq_trial[25]) begin
        sq_r <= sq_trial;
        root <= {root[22:0], 1'b1};
      end else begin
        sq_r <= {sq_r[23:0], sq_n[47:46]};
        root <= {root[22:0], 1'b0};
      end
      sq_n <= {sq_n[45:0], 2'b00};
      for (int i = 0; i < 3; i++) begin
        nm[i] <= {m[i], 23'd0};
        nr[i] <= '0;
        nq[i] <= '0;
      end
    end
    if (cmd.nd_step) begin
      for (int i = 0; i < 3; i++) begin
        logic [40:0] t;
        t = {nr[i][39:0], nm[i][39]};
        if (t >= 41'(root) && root != '0) begin
          nr[i] <= t - 41'(root);
          nq[i] <= {nq[i][38:0], 1'b1};
        end else begin
          nr[i] <= t;
          nq[i] <= {nq[i][38:0], 1'b0};
        end
        nm[i] <= {nm[i][38:0], 1'b0};
      end
    end
  end

  assign res_ok = (fcnt > CW'(10)) && (n2_100 > 43'h4000_0000) && (root != '0);
  assign res_x = res_ok ? o[0] : '0;
  assign res_y = res_ok ? o[1] : '0;
  assign res_z = res_ok ? o[2] : '0;
  assign res_cnt = fcnt[16:0];
endmodule
`default_nettype wire
